/* sv/spa_pkg.sv */
`timescale 1ns / 1ps
package spa_pkg;
    localparam int ANCHOR_COUNT_DEF = 4096;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int IDX_W = 12;
    localparam int BYTE_W = 32;
    localparam int TS_W = 64;

    typedef enum logic [1:0] {
        OP_ENTER = 2'd0,
        OP_EXIT  = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BAD       = 2'd3
    } status_t;

    // controller to datapath
    typedef struct packed {
        logic capture;     // latch input word
        logic clear_wr;    // write zero at clear address
        logic rd_item;     // read anchor table at item anchor, frame at top
        logic enter_wr;    // write anchor, push frame
        logic rd_parent;   // read anchor table at popped parent
        logic exit_a_wr;   // write popped anchor
        logic exit_p_wr;   // write parent exclusive
        logic load_result; // register result word
    } spa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic     clear_last;
        op_t      op;
        status_t  status;
        logic     same_anchor;
    } spa_stat_t;
endpackage

/* sv/scope_profile_accounting.sv */
`timescale 1ns / 1ps
// Nested scope profiler: enter, exit and read words update or report per-anchor
// time, cpu, hit and byte totals. After reset the anchor table is swept to zero,
// one entry per cycle, and no word is accepted meanwhile.
// One word is in work at a time. Enter, read and error words pass through the
// READ and DECIDE states, with the result registered in DECIDE; a good exit goes
// through READ, DECIDE, EXIT_P and EXIT_A, with the result registered in EXIT_A,
// since the popped frame must be read before its anchor and parent entries can be
// read, and the parent and the anchor are written back in separate cycles. A result
// not yet taken holds off the next word; the next word can enter as it is taken.
module scope_profile_accounting #(
    parameter int ANCHOR_COUNT = spa_pkg::ANCHOR_COUNT_DEF,
    parameter int STACK_DEPTH = spa_pkg::STACK_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_operation,
    input  logic [spa_pkg::IDX_W-1:0]  s_anchor_index,
    input  logic                       s_is_block_flag,
    input  logic [spa_pkg::BYTE_W-1:0] s_byte_count,
    input  logic [spa_pkg::TS_W-1:0]   s_os_timestamp,
    input  logic [spa_pkg::TS_W-1:0]   s_cpu_timestamp,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [1:0]                 m_status,
    output logic [spa_pkg::TS_W-1:0]   m_exclusive_time,
    output logic [spa_pkg::TS_W-1:0]   m_inclusive_time,
    output logic [spa_pkg::TS_W-1:0]   m_cpu_time,
    output logic [spa_pkg::TS_W-1:0]   m_hit_total,
    output logic [spa_pkg::TS_W-1:0]   m_byte_total,
    output logic                       m_block_mark
);
    import spa_pkg::*;

    spa_cmd_t  cmd;
    spa_stat_t stat;

    spa_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .stat, .cmd
    );

    spa_datapath #(.ANCHOR_COUNT(ANCHOR_COUNT), .STACK_DEPTH(STACK_DEPTH)) u_dp (
        .aclk, .aresetn, .cmd, .stat,
        .in_operation(s_operation),
        .in_anchor_index(s_anchor_index),
        .in_is_block_flag(s_is_block_flag),
        .in_byte_count(s_byte_count),
        .in_os_timestamp(s_os_timestamp),
        .in_cpu_timestamp(s_cpu_timestamp),
        .out_status(m_status),
        .out_exclusive_time(m_exclusive_time),
        .out_inclusive_time(m_inclusive_time),
        .out_cpu_time(m_cpu_time),
        .out_hit_total(m_hit_total),
        .out_byte_total(m_byte_total),
        .out_block_mark(m_block_mark)
    );

`ifndef ASSERT_OFF
    a_one_cmd_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({cmd.clear_wr, cmd.enter_wr, cmd.exit_a_wr, cmd.exit_p_wr}) <= 1)
        else $error("more than one anchor table write");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |=> !s_ready)
        else $error("word accepted while busy");
    a_result_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |=> m_valid)
        else $error("result lost");
`endif
endmodule

/* sv/spa_datapath.sv */
`timescale 1ns / 1ps
module spa_datapath #(
    parameter int ANCHOR_COUNT = spa_pkg::ANCHOR_COUNT_DEF,
    parameter int STACK_DEPTH = spa_pkg::STACK_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  spa_pkg::spa_cmd_t          cmd,
    output spa_pkg::spa_stat_t         stat,
    input  logic [1:0]                 in_operation,
    input  logic [spa_pkg::IDX_W-1:0]  in_anchor_index,
    input  logic                       in_is_block_flag,
    input  logic [spa_pkg::BYTE_W-1:0] in_byte_count,
    input  logic [spa_pkg::TS_W-1:0]   in_os_timestamp,
    input  logic [spa_pkg::TS_W-1:0]   in_cpu_timestamp,
    output logic [1:0]                 out_status,
    output logic [spa_pkg::TS_W-1:0]   out_exclusive_time,
    output logic [spa_pkg::TS_W-1:0]   out_inclusive_time,
    output logic [spa_pkg::TS_W-1:0]   out_cpu_time,
    output logic [spa_pkg::TS_W-1:0]   out_hit_total,
    output logic [spa_pkg::TS_W-1:0]   out_byte_total,
    output logic                       out_block_mark
);
    import spa_pkg::*;

    localparam int AW = (ANCHOR_COUNT > 1) ? $clog2(ANCHOR_COUNT) : 1;
    localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LW = $clog2(STACK_DEPTH + 1);

    // anchor table, one word per field
    logic [TS_W-1:0] excl_mem [ANCHOR_COUNT];
    logic [TS_W-1:0] incl_mem [ANCHOR_COUNT];
    logic [TS_W-1:0] cpu_mem  [ANCHOR_COUNT];
    logic [TS_W-1:0] hits_mem [ANCHOR_COUNT];
    logic [TS_W-1:0] byte_mem [ANCHOR_COUNT];
    logic            blk_mem  [ANCHOR_COUNT];

    // frame stack
    logic [AW-1:0]   fr_anchor [STACK_DEPTH];
    logic [AW-1:0]   fr_parent [STACK_DEPTH];
    logic [TS_W-1:0] fr_os     [STACK_DEPTH];
    logic [TS_W-1:0] fr_cpu    [STACK_DEPTH];
    logic [TS_W-1:0] fr_incl   [STACK_DEPTH];

    logic [AW-1:0] clr_addr_reg;
    logic [AW-1:0] parent_reg;
    logic [LW-1:0] level_reg;

    op_t             op_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             flag_reg;
    logic [BYTE_W-1:0] bytes_reg;
    logic [TS_W-1:0]  os_reg;
    logic [TS_W-1:0]  cpu_reg;

    logic [TS_W-1:0] rd_excl, rd_incl, rd_cpu, rd_hits, rd_bytes;
    logic            rd_blk;
    logic [AW-1:0]   rdf_anchor, rdf_parent;
    logic [TS_W-1:0] rdf_os, rdf_cpu, rdf_incl;
    logic [TS_W-1:0] elapsed_reg, cpu_el_reg;
    // anchor values of the popped frame, read from the table alongside the parent read
    logic [TS_W-1:0] excl_a_reg, cpu_a_reg;

    status_t       status;
    logic [AW-1:0] item_a;
    logic [SW-1:0] top;
    logic [AW-1:0] ta_addr;

    assign item_a = AW'(idx_reg);
    assign top = SW'(level_reg - LW'(1));

    always_comb begin
        status = ST_OK;
        unique case (op_reg)
            OP_ENTER: begin
                if (idx_reg == '0 || 32'(idx_reg) >= ANCHOR_COUNT) status = ST_BAD;
                else if (32'(level_reg) >= STACK_DEPTH) status = ST_OVERFLOW;
            end
            OP_EXIT:  if (level_reg == '0) status = ST_UNDERFLOW;
            OP_READ:  if (32'(idx_reg) >= ANCHOR_COUNT) status = ST_BAD;
            default:  status = ST_OK;
        endcase
    end

    assign stat.clear_last = (32'(clr_addr_reg) == ANCHOR_COUNT - 1);
    assign stat.op = op_reg;
    assign stat.status = status;
    assign stat.same_anchor = (rdf_anchor == rdf_parent);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg    <= op_t'(in_operation);
            idx_reg   <= in_anchor_index;
            flag_reg  <= in_is_block_flag;
            bytes_reg <= in_byte_count;
            os_reg    <= in_os_timestamp;
            cpu_reg   <= in_cpu_timestamp;
        end
    end

    // anchor table read port shared by item and parent reads, address picked per step
    assign ta_addr = cmd.rd_parent ? rdf_parent : item_a;

    always_ff @(posedge aclk) begin
        if (cmd.rd_item || cmd.rd_parent) begin
            rd_excl  <= excl_mem[ta_addr];
            rd_incl  <= incl_mem[ta_addr];
            rd_cpu   <= cpu_mem[ta_addr];
            rd_hits  <= hits_mem[ta_addr];
            rd_bytes <= byte_mem[ta_addr];
            rd_blk   <= blk_mem[ta_addr];
        end
        if (cmd.rd_item) begin
            rdf_anchor <= fr_anchor[top];
            rdf_parent <= fr_parent[top];
            rdf_os     <= fr_os[top];
            rdf_cpu    <= fr_cpu[top];
            rdf_incl   <= fr_incl[top];
        end
        if (cmd.rd_parent) begin
            elapsed_reg <= os_reg - rdf_os;
            cpu_el_reg  <= cpu_reg - rdf_cpu;
        end
    end

    // anchor table writes: clear sweep, enter, exit anchor, exit parent
    always_ff @(posedge aclk) begin
        if (cmd.clear_wr) begin
            excl_mem[clr_addr_reg] <= '0;
            incl_mem[clr_addr_reg] <= '0;
            cpu_mem[clr_addr_reg]  <= '0;
            hits_mem[clr_addr_reg] <= '0;
            byte_mem[clr_addr_reg] <= '0;
            blk_mem[clr_addr_reg]  <= 1'b0;
        end else if (cmd.enter_wr) begin
            hits_mem[item_a] <= rd_hits + TS_W'(1);
            byte_mem[item_a] <= rd_bytes + TS_W'(bytes_reg);
            blk_mem[item_a]  <= flag_reg;
        end else if (cmd.exit_a_wr) begin
            // rd_* holds the parent; when parent equals anchor, net exclusive unchanged
            excl_mem[rdf_anchor] <= stat.same_anchor ? rd_excl
                                                      : excl_a_reg + elapsed_reg;
            incl_mem[rdf_anchor] <= rdf_incl + elapsed_reg;
            cpu_mem[rdf_anchor]  <= cpu_a_reg + cpu_el_reg;
        end else if (cmd.exit_p_wr) begin
            excl_mem[rdf_parent] <= rd_excl - elapsed_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_parent) begin
            excl_a_reg <= excl_mem[rdf_anchor];
            cpu_a_reg  <= cpu_mem[rdf_anchor];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.enter_wr) begin
            fr_anchor[level_reg[SW-1:0]] <= item_a;
            fr_parent[level_reg[SW-1:0]] <= parent_reg;
            fr_os[level_reg[SW-1:0]]     <= os_reg;
            fr_cpu[level_reg[SW-1:0]]    <= cpu_reg;
            fr_incl[level_reg[SW-1:0]]   <= rd_incl;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
            parent_reg   <= '0;
            level_reg    <= '0;
        end else begin
            if (cmd.clear_wr) clr_addr_reg <= clr_addr_reg + AW'(1);
            if (cmd.enter_wr) begin
                parent_reg <= item_a;
                level_reg  <= level_reg + LW'(1);
            end
            if (cmd.exit_a_wr) begin
                parent_reg <= rdf_parent;
                level_reg  <= level_reg - LW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            out_status <= status;
            if (op_reg == OP_READ && status == ST_OK) begin
                out_exclusive_time <= rd_excl;
                out_inclusive_time <= rd_incl;
                out_cpu_time       <= rd_cpu;
                out_hit_total      <= rd_hits;
                out_byte_total     <= rd_bytes;
                out_block_mark     <= rd_blk;
            end else begin
                out_exclusive_time <= '0;
                out_inclusive_time <= '0;
                out_cpu_time       <= '0;
                out_hit_total      <= '0;
                out_byte_total     <= '0;
                out_block_mark     <= 1'b0;
            end
        end
    end
endmodule

/* sv/spa_ctrl.sv */
`timescale 1ns / 1ps
module spa_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  spa_pkg::spa_stat_t  stat,
    output spa_pkg::spa_cmd_t   cmd
);
    import spa_pkg::*;

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_READ   = 6'b000100,
        S_DECIDE = 6'b001000,
        S_EXIT_P = 6'b010000,
        S_EXIT_A = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign m_valid = m_valid_reg;
    // result register frees as soon as it is taken
    assign s_ready = (state_reg == S_IDLE) && (!m_valid_reg || m_ready);

    always_comb begin
        cmd = '0;
        state_next = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd.capture = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                cmd.rd_item = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (stat.op == OP_EXIT && stat.status == ST_OK) begin
                    cmd.rd_parent = 1'b1;
                    state_next = S_EXIT_P;
                end else begin
                    cmd.enter_wr = (stat.op == OP_ENTER) && (stat.status == ST_OK);
                    cmd.load_result = 1'b1;
                    m_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EXIT_P: begin
                cmd.exit_p_wr = !stat.same_anchor;
                state_next = S_EXIT_A;
            end
            S_EXIT_A: begin
                cmd.exit_a_wr = 1'b1;
                cmd.load_result = 1'b1;
                m_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end
endmodule
